[rtl/rational_arith_reduce_top_assert.svh]
// assertion macros for the rational arithmetic block
`ifndef RATIONAL_ARITH_REDUCE_TOP_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_TOP_ASSERT_SVH

// implication checked every clock outside reset
`define RAR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequent is checked on the following clock
`define RAR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rar_pkg.sv]
package rar_pkg;

   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_SUB = 2'd1;
   localparam logic [1:0] ACT_MUL = 2'd2;
   localparam logic [1:0] ACT_DIV = 2'd3;

   localparam int NUM_W = 33;
   localparam int DEN_W = 32;
   localparam int MAG_W = 33;

   typedef struct packed {
      logic load;      // capture operands
      logic mult;      // register products
      logic combine;   // form num/den
      logic gcd_init;  // load gcd operands
      logic gcd_step;  // one subtract-shift step
      logic div_init;  // start divisions
      logic div_step;  // one restoring step
      logic finish;    // apply signs, fill output
   } rar_cmd_type;

   typedef struct packed {
      logic den_zero;
      logic skip_red;
      logic gcd_done;
      logic div_done;
   } rar_sts_type;

endpackage

[rtl/rational_arith_reduce_top.sv]
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | action, four 16-bit fraction parts
// rsp     | out       | rsp_valid/rsp_stall  | result_num, result_den, status
// csr     | in        | csr_valid/csr_ready  | reduce_enable
// one word at a time; with reduction off or a zero den the gcd and divide steps are skipped
// otherwise the binary gcd loop runs, then the two shared-step restoring dividers
// reset is synchronous, active high; reduce_enable comes up as 1
// the result sits in an output register; a new word enters while it drains
module rational_arith_reduce_top
   import rar_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [15:0] req_first_num,
   input  logic signed [15:0] req_first_den,
   input  logic signed [15:0] req_second_num,
   input  logic signed [15:0] req_second_den,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [32:0] rsp_result_num,
   output logic signed [31:0] rsp_result_den,
   output logic               rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_reduce_enable
);

   rar_cmd_type cmd, cmd_dp;
   rar_sts_type sts;
   logic        red_ff;
   logic        busy;
   logic        div_last;

   // configuration register, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         red_ff <= csr_reduce_enable;
      end
   end

   rar_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd, .busy
   );

   // last divider step is when the controller leaves the divide state
   assign div_last = cmd.div_step && sts.div_done;

   rar_fin u_fin (
      .clock, .reset, .cmd_in(cmd), .div_last, .cmd_out(cmd_dp)
   );

   rar_datapath u_dp (
      .clock, .cmd(cmd_dp), .sts, .red_en(red_ff),
      .action(req_action), .first_num(req_first_num), .first_den(req_first_den),
      .second_num(req_second_num), .second_den(req_second_den),
      .res_num(rsp_result_num), .res_den(rsp_result_den), .res_status(rsp_status)
   );

   `include "rational_arith_reduce_top_assert.svh"

   `RAR_ASSERT_IMP(a_no_take_busy, busy, req_stall, "input taken while busy")
   `RAR_ASSERT_NEXT(a_rsp_holds, rsp_valid && rsp_stall, rsp_valid, "result dropped")
   `RAR_ASSERT_NEXT(a_take_busy, req_valid && !req_stall, busy, "accepted word not started")

endmodule

[rtl/rar_datapath.sv]
module rar_datapath
   import rar_pkg::*;
(
   input  logic               clock,
   input  rar_cmd_type        cmd,
   output rar_sts_type        sts,
   input  logic               red_en,
   input  logic [1:0]         action,
   input  logic signed [15:0] first_num,
   input  logic signed [15:0] first_den,
   input  logic signed [15:0] second_num,
   input  logic signed [15:0] second_den,
   output logic signed [NUM_W-1:0] res_num,
   output logic signed [DEN_W-1:0] res_den,
   output logic               res_status
);

   logic [1:0]         act_ff;
   logic signed [15:0] a_ff, b_ff, c_ff, d_ff;
   logic signed [31:0] p0_ff, p1_ff, p2_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic signed [DEN_W-1:0] den_ff;
   logic [MAG_W-1:0]   gx_ff, gy_ff;
   logic [5:0]         gk_ff;
   logic [MAG_W-1:0]   q0_ff, q1_ff, r0_ff, r1_ff, dv_ff;
   logic [5:0]         dc_ff;
   logic               red_ff;

   logic signed [31:0] m0, m1, m2;
   logic [MAG_W-1:0]   nmag, dmag, gmin, gdif;
   logic [MAG_W:0]     t0, t1;

   // products: a*d or a*c, c*b, b*d or b*c
   always_comb begin
      m0 = (act_ff == ACT_MUL) ? 32'(a_ff) * 32'(c_ff) : 32'(a_ff) * 32'(d_ff);
      m1 = 32'(c_ff) * 32'(b_ff);
      m2 = (act_ff == ACT_DIV) ? 32'(b_ff) * 32'(c_ff) : 32'(b_ff) * 32'(d_ff);
   end

   assign nmag = num_ff[NUM_W-1] ? MAG_W'(-num_ff) : MAG_W'(num_ff);
   assign dmag = den_ff[DEN_W-1] ? MAG_W'(-{den_ff[DEN_W-1], den_ff})
                                 : MAG_W'({1'b0, den_ff});
   assign gmin = (gx_ff < gy_ff) ? gx_ff : gy_ff;
   assign gdif = (gx_ff < gy_ff) ? gy_ff - gx_ff : gx_ff - gy_ff;
   assign t0 = {r0_ff, q0_ff[MAG_W-1]} - {1'b0, dv_ff};
   assign t1 = {r1_ff, q1_ff[MAG_W-1]} - {1'b0, dv_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= action;
         a_ff <= first_num;
         b_ff <= first_den;
         c_ff <= second_num;
         d_ff <= second_den;
         red_ff <= red_en;
      end
      if (cmd.mult) begin
         p0_ff <= m0;
         p1_ff <= m1;
         p2_ff <= m2;
      end
      if (cmd.combine) begin
         if ((act_ff == ACT_ADD || act_ff == ACT_SUB) && b_ff == d_ff) begin
            num_ff <= (act_ff == ACT_ADD) ? NUM_W'(a_ff) + NUM_W'(c_ff)
                                          : NUM_W'(a_ff) - NUM_W'(c_ff);
            den_ff <= DEN_W'(d_ff);
         end else begin
            priority case (act_ff)
               ACT_ADD: num_ff <= NUM_W'(p0_ff) + NUM_W'(p1_ff);
               ACT_SUB: num_ff <= NUM_W'(p0_ff) - NUM_W'(p1_ff);
               default: num_ff <= NUM_W'(p0_ff);
            endcase
            den_ff <= p2_ff;
         end
      end
      // binary gcd: strip common twos, then subtract and shift
      if (cmd.gcd_init) begin
         gx_ff <= nmag;
         gy_ff <= dmag;
         gk_ff <= '0;
      end else if (cmd.gcd_step && gx_ff != '0) begin
         if (!gx_ff[0] && !gy_ff[0]) begin
            gx_ff <= gx_ff >> 1;
            gy_ff <= gy_ff >> 1;
            gk_ff <= gk_ff + 6'd1;
         end else if (!gx_ff[0]) begin
            gx_ff <= gx_ff >> 1;
         end else if (!gy_ff[0]) begin
            gy_ff <= gy_ff >> 1;
         end else begin
            gx_ff <= gdif >> 1;
            gy_ff <= gmin;
         end
      end
      if (cmd.div_init) begin
         dv_ff <= gy_ff << gk_ff;
         q0_ff <= nmag;
         q1_ff <= dmag;
         r0_ff <= '0;
         r1_ff <= '0;
         dc_ff <= '0;
      end else if (cmd.div_step) begin
         if (!t0[MAG_W]) begin
            r0_ff <= t0[MAG_W-1:0];
            q0_ff <= {q0_ff[MAG_W-2:0], 1'b1};
         end else begin
            r0_ff <= {r0_ff[MAG_W-2:0], q0_ff[MAG_W-1]};
            q0_ff <= {q0_ff[MAG_W-2:0], 1'b0};
         end
         if (!t1[MAG_W]) begin
            r1_ff <= t1[MAG_W-1:0];
            q1_ff <= {q1_ff[MAG_W-2:0], 1'b1};
         end else begin
            r1_ff <= {r1_ff[MAG_W-2:0], q1_ff[MAG_W-1]};
            q1_ff <= {q1_ff[MAG_W-2:0], 1'b0};
         end
         dc_ff <= dc_ff + 6'd1;
      end
      if (cmd.finish) begin
         res_status <= (den_ff == '0);
         if (den_ff == '0 || !red_ff) begin
            res_num <= num_ff;
            res_den <= den_ff;
         end else begin
            res_num <= num_ff[NUM_W-1] ? -$signed(q0_ff) : $signed(q0_ff);
            res_den <= den_ff[DEN_W-1] ? -DEN_W'(q1_ff) : DEN_W'(q1_ff);
         end
      end
   end

   assign sts.den_zero = (den_ff == '0);
   assign sts.skip_red = (den_ff == '0) || !red_ff;
   assign sts.gcd_done = (gx_ff == '0);
   assign sts.div_done = (dc_ff == 6'(MAG_W - 1));

endmodule

[rtl/rar_ctrl.sv]
module rar_ctrl
   import rar_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  rar_sts_type sts,
   output rar_cmd_type cmd,
   output logic        busy
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MULT = 3'd1;
   localparam logic [2:0] ST_COMB = 3'd2;
   localparam logic [2:0] ST_CHK  = 3'd3;
   localparam logic [2:0] ST_GCD  = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       out_ff, out_in;
   logic       take;

   // a new word may enter when the controller is idle and the output slot is free or being drained
   assign req_stall = (state_ff != ST_IDLE) || (out_ff && rsp_stall);
   assign take      = req_valid && !req_stall;
   assign rsp_valid = out_ff;
   assign busy      = (state_ff != ST_IDLE);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      out_in = out_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = take;
            if (take) state_in = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_COMB;
         end
         ST_COMB: begin
            cmd.combine = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (sts.skip_red) begin
               cmd.finish = 1'b1;
               out_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.gcd_init = 1'b1;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (sts.gcd_done) begin
               cmd.div_init = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            // output load comes from the delayed last-step strobe
            out_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff <= out_in;
      end
   end

endmodule

[rtl/rar_fin.sv]
module rar_fin
   import rar_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  rar_cmd_type cmd_in,
   input  logic        div_last,
   output rar_cmd_type cmd_out
);

   // delay the output load to the cycle after the last divide step
   logic fin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff <= 1'b0;
      end else begin
         fin_ff <= div_last;
      end
   end

   always_comb begin
      cmd_out = cmd_in;
      cmd_out.finish = cmd_in.finish || fin_ff;
   end

endmodule

[verif/rar_checker.sv]
`timescale 1ns / 100ps
module rar_checker
   import rar_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [15:0] req_first_num,
   input  logic signed [15:0] req_first_den,
   input  logic signed [15:0] req_second_num,
   input  logic signed [15:0] req_second_den,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [32:0] rsp_result_num,
   input  logic signed [31:0] rsp_result_den,
   input  logic               rsp_status,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic               csr_reduce_enable,
   output int                 fail_count,
   output int                 pending,
   output int                 rsp_count
);
   typedef struct packed {
      logic signed [32:0] num;
      logic signed [31:0] den;
      logic               status;
   } fraction_type;

   fraction_type expected_q[$];
   logic         reduce_on;

   function automatic longint gcd_of(longint x, longint y);
      longint r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   function automatic fraction_type combine_fraction(logic [1:0] act, longint a, longint b,
                                                     longint c, longint d, logic red);
      fraction_type f;
      longint       n, m, g;
      case (act)
         ACT_ADD: begin
            if (b == d) begin n = a + c; m = d; end
            else begin n = a * d + c * b; m = b * d; end
         end
         ACT_SUB: begin
            if (b == d) begin n = a - c; m = d; end
            else begin n = a * d - c * b; m = b * d; end
         end
         ACT_MUL: begin n = a * c; m = b * d; end
         default: begin n = a * d; m = b * c; end
      endcase
      f.status = (m == 0);
      if (m != 0 && red) begin
         g = gcd_of(n < 0 ? -n : n, m < 0 ? -m : m);
         if (g != 0) begin
            n = n / g;
            m = m / g;
         end
      end
      f.num = n[32:0];
      f.den = m[31:0];
      return f;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      fraction_type want;
      if (reset) begin
         reduce_on <= 1'b1;
         fail_count <= 0;
         rsp_count <= 0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) reduce_on <= csr_reduce_enable;
         if (rsp_valid && !rsp_stall) begin
            rsp_count <= rsp_count + 1;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected word num=%0d den=%0d", $time,
                        rsp_result_num, rsp_result_den);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (want.num !== rsp_result_num || want.den !== rsp_result_den
                   || want.status !== rsp_status) begin
                  $display("%0t: mismatch expected %0d/%0d st %0d, got %0d/%0d st %0d",
                           $time, want.num, want.den, want.status,
                           rsp_result_num, rsp_result_den, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_q.push_back(combine_fraction(req_action, req_first_num,
               req_first_den, req_second_num, req_second_den, reduce_on));
      end
   end
endmodule

[verif/tb_rational_arith_reduce_top.sv]
`timescale 1ns / 100ps
module tb_rational_arith_reduce_top;
   import rar_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_action = ACT_ADD;
   logic signed [15:0] req_first_num = '0;
   logic signed [15:0] req_first_den = '0;
   logic signed [15:0] req_second_num = '0;
   logic signed [15:0] req_second_den = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [32:0] rsp_result_num;
   logic signed [31:0] rsp_result_den;
   logic               rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_reduce_enable = 1'b0;
   int                 fail_count, pending, rsp_count;
   int                 idle_cycles;
   bit                 calm;    // no idling on either side while set
   int                 word_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rational_arith_reduce_top dut (.*);
   rar_checker u_checker (.*);

   // receiver stalls at random, with about 11 percent chance, unless in the calm stretch
   always @(posedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 11);

   // watchdog: cycles with no word moving on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("simulation failed");
         $finish;
      end
   end

   // one word on the request channel, with random idle gaps before it
   task automatic send_word(logic [1:0] act, logic [15:0] a, logic [15:0] b,
                            logic [15:0] c, logic [15:0] d);
      while (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_first_num <= a;
      req_first_den <= b;
      req_second_num <= c;
      req_second_den <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      word_count++;
   endtask

   // drop the request and wait until every expected result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // drain, let the block settle, then write the reduce enable
   task automatic write_reduce(logic en);
      drain();
      repeat (120) @(posedge clock);
      csr_valid <= 1'b1;
      csr_reduce_enable <= en;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // operand picker biased toward edges and small values; random_words adds shared denominators
   function automatic logic [15:0] pick_part();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(8)) - 4);
         4, 5: return 16'(int'($urandom_range(200)) - 100);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_words(int n);
      logic [15:0] b, d;
      for (int i = 0; i < n; i++) begin
         b = pick_part();
         d = ($urandom_range(3) == 0) ? b : pick_part();
         send_word(2'($urandom_range(3)), pick_part(), b, pick_part(), d);
      end
   endtask

   initial begin
      calm = 1'b0;
      word_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: each op, extremes, zero den, zero numerator, shared den
      send_word(ACT_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
      send_word(ACT_ADD, 16'sd1, 16'sd3, 16'sd1, 16'sd6);
      send_word(ACT_SUB, 16'sd3, 16'sd4, 16'sd5, 16'sd4);
      send_word(ACT_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
      send_word(ACT_MUL, 16'sd6, 16'sd8, -16'sd4, 16'sd9);
      send_word(ACT_DIV, 16'sd2, 16'sd3, 16'sd4, 16'sd5);
      send_word(ACT_DIV, 16'sd2, 16'sd3, 16'sd0, 16'sd5);
      send_word(ACT_ADD, 16'sd5, 16'sd0, 16'sd3, 16'sd7);
      send_word(ACT_MUL, 16'sd0, 16'sd7, 16'sd3, -16'sd9);
      send_word(ACT_SUB, 16'sd4, -16'sd6, 16'sd4, -16'sd6);
      send_word(ACT_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
      send_word(ACT_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      send_word(ACT_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_word(ACT_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_word(ACT_DIV, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_word(ACT_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      write_reduce(1'b0);
      send_word(ACT_ADD, 16'sd2, 16'sd4, 16'sd2, 16'sd4);
      send_word(ACT_MUL, 16'sd0, 16'sd5, 16'sd7, 16'sd0);
      send_word(ACT_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);

      random_words(500);
      write_reduce(1'b1);
      random_words(400);
      // sender holds off until the pipeline is empty
      drain();
      calm = 1'b1;
      random_words(300);
      calm = 1'b0;
      write_reduce(1'b0);
      random_words(300);
      write_reduce(1'b1);
      random_words(300);

      drain();
      repeat (150) @(posedge clock);
      $display("ran %0d words through add, subtract, multiply and divide", word_count);
      $display("with reduction toggled, edge operands and zero denominators");
      if (fail_count == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
